// ----- hdl/fbc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fbc_pkg;

	localparam int LANE_BITS   = 16;
	localparam int NUM_LANES   = 4;
	localparam int NUM_AXES    = 3;
	localparam int NUM_PLANES  = 6;
	localparam int NUM_GROUPS  = 4;
	localparam int COORD_FRAC  = 4;
	localparam int CFG_DATA_W  = 64;
	localparam int CFG_INDEX_W = 8;

	// register indexes on the configuration port
	localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_GROUP_0 = 8'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_GROUP_1 = 8'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_GROUP_2 = 8'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_MATRIX_GROUP_3 = 8'd3;

	// identity matrix, 1.0 in Q4.12 on the diagonal
	localparam logic [CFG_DATA_W-1:0] MATRIX_GROUP_0_RESET = 64'h0000_0000_0000_1000;
	localparam logic [CFG_DATA_W-1:0] MATRIX_GROUP_1_RESET = 64'h0000_0000_1000_0000;
	localparam logic [CFG_DATA_W-1:0] MATRIX_GROUP_2_RESET = 64'h0000_1000_0000_0000;
	localparam logic [CFG_DATA_W-1:0] MATRIX_GROUP_3_RESET = 64'h1000_0000_0000_0000;

	typedef struct packed {
		logic v1;
		logic v2;
		logic v3;
	} pipe_status_t;

endpackage

`default_nettype wire

// ----- hdl/fbc_planes.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fbc_planes #(
	parameter int MW = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	input  wire logic [fbc_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [fbc_pkg::CFG_DATA_W-1:0]      cfg_data,
	output wire logic signed [MW:0] normal [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES],
	output wire logic signed [MW:0] offset [fbc_pkg::NUM_PLANES]
);

	logic [fbc_pkg::CFG_DATA_W-1:0] grp_q [fbc_pkg::NUM_GROUPS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grp_q[0] <= fbc_pkg::MATRIX_GROUP_0_RESET;
			grp_q[1] <= fbc_pkg::MATRIX_GROUP_1_RESET;
			grp_q[2] <= fbc_pkg::MATRIX_GROUP_2_RESET;
			grp_q[3] <= fbc_pkg::MATRIX_GROUP_3_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				fbc_pkg::REG_MATRIX_GROUP_0: begin
					grp_q[0] <= cfg_data;
				end
				fbc_pkg::REG_MATRIX_GROUP_1: begin
					grp_q[1] <= cfg_data;
				end
				fbc_pkg::REG_MATRIX_GROUP_2: begin
					grp_q[2] <= cfg_data;
				end
				fbc_pkg::REG_MATRIX_GROUP_3: begin
					grp_q[3] <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// plane pair per row: fourth row plus and minus that row
	for (genvar gr = 0; gr < 3; gr++) begin : g_row
		for (genvar gs = 0; gs < 2; gs++) begin : g_side
			for (genvar gk = 0; gk < fbc_pkg::NUM_LANES; gk++) begin : g_lane
				logic signed [MW:0] a;
				logic signed [MW:0] b;
				logic signed [MW:0] n;
				assign a = (MW+1)'($signed(grp_q[3][fbc_pkg::LANE_BITS*gk +: MW]));
				assign b = (MW+1)'($signed(grp_q[gr][fbc_pkg::LANE_BITS*gk +: MW]));
				assign n = (gs == 1) ? a - b : a + b;
				if (gk < fbc_pkg::NUM_AXES) begin : g_norm
					assign normal[2*gr+gs][gk] = n;
				end else begin : g_offset
					assign offset[2*gr+gs] = n;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ----- hdl/fbc_eval.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fbc_eval #(
	parameter int MW = 16,
	parameter int CW = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  advance,
	input  wire logic                  in_valid,
	input  wire logic signed [CW-1:0]  box_min [fbc_pkg::NUM_AXES],
	input  wire logic signed [CW-1:0]  box_max [fbc_pkg::NUM_AXES],
	input  wire logic signed [MW:0]    normal [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES],
	input  wire logic signed [MW:0]    offset [fbc_pkg::NUM_PLANES],
	output fbc_pkg::pipe_status_t      status,
	output logic                       valid_s4,
	output logic                       visible_s4
);

	localparam int PW = MW + 1 + CW;
	localparam int SW = PW + 2;

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic [fbc_pkg::NUM_PLANES-1:0] neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	for (genvar gp = 0; gp < fbc_pkg::NUM_PLANES; gp++) begin : g_plane
		logic signed [CW-1:0] corner_s1 [fbc_pkg::NUM_AXES];
		logic signed [PW-1:0] prod_s2   [fbc_pkg::NUM_AXES];
		logic signed [SW-1:0] psum_a_s3;
		logic signed [SW-1:0] psum_b_s3;
		logic signed [SW-1:0] total;

		for (genvar gk = 0; gk < fbc_pkg::NUM_AXES; gk++) begin : g_axis
			logic pos;
			// furthest corner along the normal: max for a strictly positive component
			assign pos = !normal[gp][gk][MW] && (normal[gp][gk] != '0);

			always_ff @(posedge clk) begin
				if (advance) begin
					corner_s1[gk] <= pos ? box_max[gk] : box_min[gk];
					prod_s2[gk]   <= PW'(normal[gp][gk]) * PW'(corner_s1[gk]);
				end
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				psum_a_s3 <= SW'(prod_s2[0]) + SW'(prod_s2[1]);
				psum_b_s3 <= SW'(prod_s2[2]) + (SW'(offset[gp]) <<< fbc_pkg::COORD_FRAC);
			end
		end

		assign total   = psum_a_s3 + psum_b_s3;
		assign neg[gp] = total[SW-1];
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			visible_s4 <= ~|neg;
		end
	end

	assign status.v1 = valid_s1;
	assign status.v2 = valid_s2;
	assign status.v3 = valid_s3;

endmodule

`default_nettype wire

// ----- hdl/frustum_box_cull.sv -----
// channel  | handshake              | payload
// in       | in_valid / in_ready    | box_min_x/y/z, box_max_x/y/z
// out      | out_valid / out_ready  | visible
// cfg      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one box per cycle unless the output is held; a box reaches the output
// through corner select, multiply, partial sum and sign-reduce register stages
// the four-stage pipeline moves as a whole; a held output stalls every stage
// and in_ready drops, so nothing is lost or repeated
// cfg_ready is always high; reset loads the identity matrix and empties the pipe
`timescale 1ns / 1ps
`default_nettype none

module frustum_box_cull #(
	parameter int COORD_WIDTH  = 16,
	parameter int MATRIX_WIDTH = 16
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic signed [COORD_WIDTH-1:0]    box_min_x,
	input  wire logic signed [COORD_WIDTH-1:0]    box_min_y,
	input  wire logic signed [COORD_WIDTH-1:0]    box_min_z,
	input  wire logic signed [COORD_WIDTH-1:0]    box_max_x,
	input  wire logic signed [COORD_WIDTH-1:0]    box_max_y,
	input  wire logic signed [COORD_WIDTH-1:0]    box_max_z,
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic                                  visible,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [fbc_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  wire logic [fbc_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic signed [MATRIX_WIDTH:0]  normal [fbc_pkg::NUM_PLANES][fbc_pkg::NUM_AXES];
	logic signed [MATRIX_WIDTH:0]  offset [fbc_pkg::NUM_PLANES];
	logic signed [COORD_WIDTH-1:0] box_min [fbc_pkg::NUM_AXES];
	logic signed [COORD_WIDTH-1:0] box_max [fbc_pkg::NUM_AXES];
	fbc_pkg::pipe_status_t         status;
	logic                          valid_s4;
	logic                          visible_s4;
	logic                          advance;

	assign box_min[0] = box_min_x;
	assign box_min[1] = box_min_y;
	assign box_min[2] = box_min_z;
	assign box_max[0] = box_max_x;
	assign box_max[1] = box_max_y;
	assign box_max[2] = box_max_z;

	assign advance   = !valid_s4 || out_ready;
	assign in_ready  = advance;
	assign out_valid = valid_s4;
	assign visible   = visible_s4;
	assign cfg_ready = 1'b1;

	fbc_planes #(
		.MW(MATRIX_WIDTH)
	) u_planes (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.normal   (normal),
		.offset   (offset)
	);

	fbc_eval #(
		.MW(MATRIX_WIDTH),
		.CW(COORD_WIDTH)
	) u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (in_valid),
		.box_min   (box_min),
		.box_max   (box_max),
		.normal    (normal),
		.offset    (offset),
		.status    (status),
		.valid_s4  (valid_s4),
		.visible_s4(visible_s4)
	);

`ifndef SYNTH
	// an accepted box reaches the output if the output is not held on the way
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		($past(in_valid && in_ready, 3) && $past(arst_n, 3) && $past(arst_n, 2)
			&& $past(arst_n, 1) && $past(out_ready, 2) && $past(out_ready, 1) && out_ready)
		|=> out_valid)
		else $error("accepted box did not reach the output on time");

	// an empty third stage never produces a result when the pipe advances
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		(!status.v3 && in_ready) |=> !out_valid)
		else $error("result appeared without a transaction behind it");

	// a stalled output freezes the whole pipe
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> $stable(status))
		else $error("pipeline moved while the output was stalled");
`endif

endmodule

`default_nettype wire
